FILE: hdl/sfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants of the frame deframer: event codes, special
// characters, parse phases and the queue entry between front and back.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Event codes carried on the result channel
  localparam logic [2:0] EV_CMD_BYTE = 3'd0;
  localparam logic [2:0] EV_CMD_END  = 3'd1;
  localparam logic [2:0] EV_KEY_BYTE = 3'd2;
  localparam logic [2:0] EV_VAL_BYTE = 3'd3;
  localparam logic [2:0] EV_HDR_END  = 3'd4;
  localparam logic [2:0] EV_HDR_DROP = 3'd5;
  localparam logic [2:0] EV_BODY     = 3'd6;
  localparam logic [2:0] EV_FRAME    = 3'd7;

  // Characters with a meaning to the parser
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_CMD  = 5'b00010,
    PH_KEY  = 5'b00100,
    PH_VAL  = 5'b01000,
    PH_BODY = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data;
  } result_t;

  // One input byte's worth of results: one or two
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  // Queue head as seen by the back part
  typedef struct packed {
    logic   avail;
    entry_t head;
  } qhead_t;

endpackage
`default_nettype wire

FILE: hdl/sfd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_if
// Handshake channels of the deframer: raw byte input and tagged result output.
// ----------------------------------------------------------------------------
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output event_res, output out_byte, output last,
                  input ready);
  modport sink   (input valid, input event_res, input out_byte, input last,
                  output ready);
endinterface
`default_nettype wire

FILE: hdl/sfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_front
// Parser front: accepts raw bytes, tracks the frame phase and turns each
// byte into zero, one or two tagged results pushed into the queue.
// ----------------------------------------------------------------------------
module sfd_front
  import sfd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  sfd_in_if.sink      bytes,
  input  wire logic   q_full,
  output logic        push,
  output entry_t      push_entry
);

  phase_t     phase, phase_next;
  logic       escape_pending, escape_pending_next;
  logic       line_empty, line_empty_next;
  logic       accept;
  logic       emit;
  logic [7:0] b;

  assign bytes.ready = !q_full;
  assign accept      = bytes.valid && bytes.ready;
  assign b           = bytes.in_byte;
  assign push        = accept && emit;

  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    line_empty_next     = line_empty;
    emit                = 1'b0;
    push_entry          = '0;
    case (phase)
      PH_CMD: begin
        if (b == CH_CR) begin
        end else if (b == CH_LF) begin
          emit                 = 1'b1;
          push_entry.r0        = '{EV_CMD_END, 8'h00};
          phase_next           = PH_KEY;
          line_empty_next      = 1'b1;
        end else begin
          emit                 = 1'b1;
          push_entry.r0        = '{EV_CMD_BYTE, b};
        end
      end
      PH_KEY: begin
        if (b == CH_CR) begin
        end else if (b == CH_LF) begin
          if (line_empty) begin
            phase_next = PH_BODY;
          end else begin
            emit            = 1'b1;
            push_entry.r0   = '{EV_HDR_DROP, 8'h00};
            line_empty_next = 1'b1;
          end
        end else if (b == CH_COLON) begin
          phase_next      = PH_VAL;
          line_empty_next = 1'b0;
        end else begin
          emit            = 1'b1;
          push_entry.r0   = '{EV_KEY_BYTE, b};
          line_empty_next = 1'b0;
        end
      end
      PH_VAL: begin
        if (b == CH_CR) begin
        end else if (b == CH_LF) begin
          emit = 1'b1;
          // flush a dangling backslash ahead of the header end
          if (escape_pending) begin
            push_entry.two = 1'b1;
            push_entry.r0  = '{EV_VAL_BYTE, CH_BSL};
            push_entry.r1  = '{EV_HDR_END, 8'h00};
          end else begin
            push_entry.r0  = '{EV_HDR_END, 8'h00};
          end
          escape_pending_next = 1'b0;
          phase_next          = PH_KEY;
          line_empty_next     = 1'b1;
        end else if (escape_pending) begin
          escape_pending_next = 1'b0;
          emit                = 1'b1;
          if (b == CH_LC_C) begin
            push_entry.r0 = '{EV_VAL_BYTE, CH_COLON};
          end else if (b == CH_BSL) begin
            push_entry.r0 = '{EV_VAL_BYTE, CH_BSL};
          end else if (b == CH_LC_N) begin
            push_entry.r0 = '{EV_VAL_BYTE, CH_LF};
          end else if (b == CH_LC_R) begin
            push_entry.r0 = '{EV_VAL_BYTE, CH_CR};
          end else begin
            // unknown escape: pass both bytes on
            push_entry.two = 1'b1;
            push_entry.r0  = '{EV_VAL_BYTE, CH_BSL};
            push_entry.r1  = '{EV_VAL_BYTE, b};
          end
        end else if (b == CH_BSL) begin
          escape_pending_next = 1'b1;
        end else begin
          emit          = 1'b1;
          push_entry.r0 = '{EV_VAL_BYTE, b};
        end
      end
      PH_BODY: begin
        emit = 1'b1;
        if (b == CH_NUL) begin
          push_entry.r0       = '{EV_FRAME, 8'h00};
          phase_next          = PH_IDLE;
          line_empty_next     = 1'b1;
          escape_pending_next = 1'b0;
        end else begin
          push_entry.r0 = '{EV_BODY, b};
        end
      end
      default: begin
        phase_next = PH_IDLE;
        // skip keep-alive line breaks
        if (b != CH_CR && b != CH_LF) begin
          emit          = 1'b1;
          push_entry.r0 = '{EV_CMD_BYTE, b};
          phase_next    = PH_CMD;
        end
        escape_pending_next = 1'b0;
        line_empty_next     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      escape_pending <= 1'b0;
      line_empty     <= 1'b1;
    end else if (accept) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      line_empty     <= line_empty_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sfd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_queue
// Short request queue between parser front and result back; lets either
// side stall without holding up the other.
// ----------------------------------------------------------------------------
module sfd_queue
  import sfd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output qhead_t      qhead
);

  entry_t         slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           do_pop;

  assign full        = (count == (QAW+1)'(QDEPTH));
  assign qhead.avail = (count != '0);
  assign qhead.head  = slots[rd_ptr];
  assign do_pop      = pop && qhead.avail;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_back
// Result back: drains queued requests into the output register, one result
// per cycle while the receiver takes them, marking each byte's last result.
// ----------------------------------------------------------------------------
module sfd_back
  import sfd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire qhead_t qhead,
  output logic        pop,
  sfd_out_if.source   results
);

  logic    second;
  logic    load;
  result_t pick;
  logic    pick_last;

  assign load = qhead.avail && (!results.valid || results.ready);

  always_comb begin
    if (second) begin
      pick      = qhead.head.r1;
      pick_last = 1'b1;
    end else begin
      pick      = qhead.head.r0;
      pick_last = !qhead.head.two;
    end
  end

  // release the request once its final result is loaded
  assign pop = load && pick_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
      second        <= 1'b0;
    end else begin
      if (load) begin
        results.valid <= 1'b1;
        second        <= !pick_last;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.event_res <= pick.event_res;
      results.out_byte  <= pick.data;
      results.last      <= pick_last;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/stomp_frame_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stomp_frame_deframer
// Tags a raw text-frame byte stream: command, header key/value, body, ends.
// ----------------------------------------------------------------------------
// Usage:
//   bytes  : valid/ready channel carrying one raw byte (in_byte) per request.
//   events : valid/ready channel carrying event_res, out_byte and last.
//   Each input byte yields zero, one or two results; last marks the final
//   result of a byte. Line breaks before a command, stray CRs, the header
//   colon and a backslash that starts an escape yield nothing.
//   Path: a byte's results are written into the queue at the accepting
//   edge and then loaded into the output register once it is free; a
//   receiver stall can hold them in the queue.
//   Throughput: one byte per cycle in while the queue is not full; one
//   result per cycle out while the receiver takes them. A two-result byte
//   holds the output for both in turn; the four-entry queue absorbs bursts.
//   Reset (rst, synchronous): parser goes idle, queue empties, output valid
//   drops. No clearing pass is needed.
//   Receiver stall: the output register holds its result; the queue keeps
//   filling and bytes.ready falls only when the queue is full.
// ----------------------------------------------------------------------------
module stomp_frame_deframer
  import sfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sfd_in_if.sink    bytes,
  sfd_out_if.source events
);

  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   q_full;
  qhead_t qhead;

  sfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  sfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .qhead      (qhead)
  );

  sfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .qhead   (qhead),
    .pop     (pop),
    .results (events)
  );

endmodule
`default_nettype wire

FILE: verif/sfd_tag_check.sv
// ----------------------------------------------------------------------------
// sfd_tag_check
// Watches both channels of the frame deframer. It tags every accepted byte
// the way the parser should and compares each accepted result with the
// oldest tag still due.
// ----------------------------------------------------------------------------
module sfd_tag_check
  import sfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  sfd_in_if         in_ch,
  sfd_out_if        out_ch,
  output int        fail_count,
  output int        tags_pending
);

  typedef struct {
    logic [2:0] ev;
    logic [7:0] data;
    logic       last;
  } tag_t;

  tag_t   tags_due[$];
  tag_t   step_tags[$];
  phase_t parse_ph;
  logic   esc_open;
  logic   line_blank;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < 40) begin
      $display("%0t mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  function automatic void note(input logic [2:0] ev, input logic [7:0] data);
    tag_t t;
    t.ev   = ev;
    t.data = data;
    t.last = 1'b0;
    step_tags.push_back(t);
  endfunction

  // Advance the parse state by one byte and queue the results it causes
  function automatic void tag_byte(input logic [7:0] b);
    tag_t t;
    step_tags.delete();
    case (parse_ph)
      PH_CMD: begin
        if (b == CH_LF) begin
          note(EV_CMD_END, '0);
          parse_ph   = PH_KEY;
          line_blank = 1'b1;
        end else if (b != CH_CR) begin
          note(EV_CMD_BYTE, b);
        end
      end
      PH_KEY: begin
        if (b == CH_LF) begin
          if (line_blank) begin
            parse_ph = PH_BODY;
          end else begin
            note(EV_HDR_DROP, '0);
            line_blank = 1'b1;
          end
        end else if (b == CH_COLON) begin
          parse_ph   = PH_VAL;
          line_blank = 1'b0;
        end else if (b != CH_CR) begin
          note(EV_KEY_BYTE, b);
          line_blank = 1'b0;
        end
      end
      PH_VAL: begin
        if (b == CH_LF) begin
          if (esc_open) note(EV_VAL_BYTE, CH_BSL);
          note(EV_HDR_END, '0);
          esc_open   = 1'b0;
          parse_ph   = PH_KEY;
          line_blank = 1'b1;
        end else if (b == CH_CR) begin
          // stray CR: nothing changes
        end else if (esc_open) begin
          esc_open = 1'b0;
          case (b)
            CH_LC_C: note(EV_VAL_BYTE, CH_COLON);
            CH_BSL:  note(EV_VAL_BYTE, CH_BSL);
            CH_LC_N: note(EV_VAL_BYTE, CH_LF);
            CH_LC_R: note(EV_VAL_BYTE, CH_CR);
            default: begin
              // unknown escape: pass both bytes on
              note(EV_VAL_BYTE, CH_BSL);
              note(EV_VAL_BYTE, b);
            end
          endcase
        end else if (b == CH_BSL) begin
          esc_open = 1'b1;
        end else begin
          note(EV_VAL_BYTE, b);
        end
      end
      PH_BODY: begin
        if (b == CH_NUL) begin
          note(EV_FRAME, '0);
          parse_ph   = PH_IDLE;
          line_blank = 1'b1;
          esc_open   = 1'b0;
        end else begin
          note(EV_BODY, b);
        end
      end
      default: begin
        parse_ph = PH_IDLE;
        if (b != CH_CR && b != CH_LF) begin
          note(EV_CMD_BYTE, b);
          parse_ph = PH_CMD;
        end
        esc_open   = 1'b0;
        line_blank = 1'b1;
      end
    endcase
    foreach (step_tags[i]) begin
      t      = step_tags[i];
      t.last = (i == step_tags.size() - 1);
      tags_due.push_back(t);
    end
  endfunction

  always @(posedge clk) begin
    tag_t want;
    if (rst) begin
      parse_ph   = PH_IDLE;
      esc_open   = 1'b0;
      line_blank = 1'b1;
      fail_count = 0;
      tags_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) tag_byte(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (tags_due.size() == 0) begin
          report_mismatch("result with no tag due, event", out_ch.event_res, 0);
        end else begin
          want = tags_due.pop_front();
          if (out_ch.event_res !== want.ev)
            report_mismatch("event_res", out_ch.event_res, want.ev);
          if (out_ch.out_byte !== want.data)
            report_mismatch("out_byte", out_ch.out_byte, want.data);
          if (out_ch.last !== want.last)
            report_mismatch("last", out_ch.last, want.last);
        end
      end
    end
    tags_pending = tags_due.size();
  end

endmodule

FILE: verif/stomp_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// stomp_frame_deframer_tb
// Drives the deframer with a short hand-built frame that touches each parse
// phase, then with random frames and raw noise, under random sender bursts
// and receiver stalls. A tag checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module stomp_frame_deframer_tb;
  import sfd_pkg::*;

  localparam int ITEM_TARGET = 400;
  localparam int STALL_LIMIT = 2000;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HALF, RX_PULSE} rx_style_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  int        fail_count;
  int        tags_pending;
  int        bytes_sent = 0;
  int        burst_left = 0;
  int        quiet_cycles = 0;
  int        rx_span = 0;
  rx_style_t rx_style = RX_OPEN;

  // command NUL, stray CR, empty key, second colon, all escapes, unknown
  // escape, escape at line end, line with no colon, blank line, CR/LF in body
  logic [7:0] opening_seq [25] = '{
    CH_CR, CH_LF, CH_NUL, CH_CR, CH_LF, CH_COLON, CH_COLON,
    CH_BSL, CH_LC_C, CH_BSL, CH_BSL, CH_BSL, CH_LC_N, CH_BSL, CH_LC_R,
    CH_BSL, 8'hFF, CH_BSL, CH_LF, 8'h6B, CH_LF, CH_LF, CH_CR, CH_LF, CH_NUL
  };

  sfd_in_if  bytes_ch ();
  sfd_out_if events_ch ();

  stomp_frame_deframer dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_ch),
    .events (events_ch)
  );

  sfd_tag_check u_tag_check (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (bytes_ch),
    .out_ch       (events_ch),
    .fail_count   (fail_count),
    .tags_pending (tags_pending)
  );

  always #5 clk = ~clk;

  // Bias toward the characters the parser reacts to
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_COLON;
      3:       return CH_BSL;
      4:       return CH_NUL;
      5:       return $urandom_range(0, 1) ? CH_LC_C : ($urandom_range(0, 1) ? CH_LC_N : CH_LC_R);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    bytes_ch.valid   <= 1'b1;
    bytes_ch.in_byte <= b;
    do @(posedge clk); while (!bytes_ch.ready);
    @(negedge clk);
    if (b != CH_CR) bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        bytes_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  endtask

  // Receiver: switch stall style every so often
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_style <= rx_style_t'($urandom_range(0, 3));
      rx_span  <= $urandom_range(20, 120);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_style)
      RX_OPEN:  events_ch.ready <= 1'b1;
      RX_LIGHT: events_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_HALF:  events_ch.ready <= 1'($urandom_range(0, 1));
      default:  events_ch.ready <= (rx_span % 7 < 2);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (bytes_ch.valid && bytes_ch.ready) || (events_ch.valid && events_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0] b;
    logic       has_colon;
    bytes_ch.valid   = 1'b0;
    bytes_ch.in_byte = '0;
    events_ch.ready  = 1'b0;
    burst_left       = $urandom_range(1, 40);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_seq[i]) send_byte(opening_seq[i]);

    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) begin
        // raw noise, may leave the parser mid-frame
        repeat ($urandom_range(3, 16)) send_byte(pick_byte());
      end else begin
        repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
        do b = pick_byte(); while (b == CH_CR || b == CH_LF);
        send_byte(b);
        repeat ($urandom_range(0, 5)) begin
          do b = pick_byte(); while (b == CH_LF);
          send_byte(b);
        end
        send_byte(CH_LF);
        repeat ($urandom_range(0, 3)) begin
          has_colon = ($urandom_range(0, 7) != 0);
          // a line with no colon needs a key byte, else it reads as blank
          repeat ($urandom_range(has_colon ? 0 : 1, 4)) begin
            do b = pick_byte(); while (b == CH_LF || b == CH_COLON || b == CH_CR);
            send_byte(b);
          end
          if (has_colon) begin
            send_byte(CH_COLON);
            repeat ($urandom_range(0, 6)) begin
              if ($urandom_range(0, 3) == 0) begin
                send_byte(CH_BSL);
                case ($urandom_range(0, 4))
                  0:       send_byte(CH_LC_C);
                  1:       send_byte(CH_BSL);
                  2:       send_byte(CH_LC_N);
                  3:       send_byte(CH_LC_R);
                  default: send_byte(pick_byte());
                endcase
              end else begin
                do b = pick_byte(); while (b == CH_LF);
                send_byte(b);
              end
            end
          end
          if ($urandom_range(0, 2) == 0) send_byte(CH_CR);
          send_byte(CH_LF);
        end
        if ($urandom_range(0, 2) == 0) send_byte(CH_CR);
        send_byte(CH_LF);
        repeat ($urandom_range(0, 8)) begin
          do b = pick_byte(); while (b == CH_NUL);
          send_byte(b);
        end
        send_byte(CH_NUL);
      end
    end

    bytes_ch.valid <= 1'b0;
    while (tags_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
